FILE: hw/rtl/gcra_pkg.sv
// Package for the grid contiguous-run allocator.
// Item and result types, operation codes and register indexes.
// No dependencies.
package gcra_pkg;

  localparam int OP_W       = 1;
  localparam int RUN_LEN_W  = 3;
  localparam int TAG_W      = 32;
  localparam int ROW_OUT_W  = 3;
  localparam int COL_OUT_W  = 4;
  localparam int FREE_OUT_W = 8;

  localparam int ROWS_REG_W = 4;
  localparam int COLS_REG_W = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam int ROWS_RESET = 8;
  localparam int COLS_RESET = 16;

  localparam logic [OP_W-1:0] OP_ALLOC   = 1'b0;
  localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [RUN_LEN_W-1:0] run_length;
    logic [TAG_W-1:0]     tag;
  } gcra_in_t;

  typedef struct packed {
    logic                  success;
    logic [ROW_OUT_W-1:0]  row;
    logic [COL_OUT_W-1:0]  start_column;
    logic [FREE_OUT_W-1:0] free_cells;
  } gcra_out_t;

endpackage

FILE: hw/rtl/grid_contiguous_run_allocator.sv
// Grid contiguous-run allocator: top level, scan sequencer and tag memory.
// Depends on gcra_pkg.
//
//  port group   direction  handshake          payload
//  in_*         input      in_valid/in_stall  gcra_in_t   (operation, run_length, tag)
//  out_*        output     out_valid/out_stall gcra_out_t (success, row, start_column,
//                                                           free_cells)
//  cfg_*        input      cfg_we             cfg_index, cfg_wdata
//
// One cell is visited per cycle by a single compare/count unit.
// Allocate: scans cells (up to rows*cols), then writes run_length cells when placed.
// Release: scans every cell of the used grid (tag memory read is registered, one cell a cycle).
// An allocate with a bad run length, or any item on an empty grid, goes straight to the result.
// Synchronous active-low reset frees every cell; a register write does the same at once.
// A finished result waits in the output register; the next item is taken meanwhile,
// and a result that finds the output register still full waits for it to drain.
module grid_contiguous_run_allocator #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 16,
  parameter int MAX_RUN  = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  gcra_pkg::gcra_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output gcra_pkg::gcra_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [gcra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gcra_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import gcra_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ERW   = $clog2(MAX_ROWS + 1);
  localparam int ECW   = $clog2(MAX_COLS + 1);
  localparam int FW    = $clog2(CELLS + 1);
  localparam int LW    = $clog2(MAX_RUN + 1);
  localparam int RST_NR = (ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET;
  localparam int RST_NC = (COLS_RESET > MAX_COLS) ? MAX_COLS : COLS_RESET;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_ALLOC    = 6'b000010,
    S_FILL     = 6'b000100,
    S_REL      = 6'b001000,
    S_REL_TAIL = 6'b010000,
    S_DONE     = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic [ROWS_REG_W-1:0] rows_used_r;
  logic [COLS_REG_W-1:0] cols_used_r;
  logic [CELLS-1:0]      busy_r;
  logic [FW-1:0]         free_r;
  logic [RW-1:0]         row_r;
  logic [CW-1:0]         col_r;
  logic [LW-1:0]         cnt_r;
  logic [LW-1:0]         len_r;
  logic [TAG_W-1:0]      tag_r;
  logic [OP_W-1:0]       op_r;
  logic [CW-1:0]         start_r;
  logic                  ok_r;
  logic                  rd_v_r;
  logic [AW-1:0]         rd_idx_r;
  logic [TAG_W-1:0]      rd_data_r;
  logic                  out_valid_r;
  gcra_out_t             out_data_r;

  logic [TAG_W-1:0]      tag_mem [CELLS];

  logic [ERW-1:0]        nr;
  logic [ECW-1:0]        nc;
  logic [ROWS_REG_W-1:0] new_rows;
  logic [COLS_REG_W-1:0] new_cols;
  logic [ERW-1:0]        new_nr;
  logic [ECW-1:0]        new_nc;
  logic [FW-1:0]         free_load;
  logic [AW-1:0]         idx;
  logic                  in_acc;
  logic                  len_ok;
  logic                  grid_empty;
  logic                  last_col;
  logic [LW-1:0]         cnt_nxt;
  logic                  run_found;
  logic                  rel_hit;
  logic                  out_free;

  assign nr = (rows_used_r > MAX_ROWS) ? ERW'(MAX_ROWS) : ERW'(rows_used_r);
  assign nc = (cols_used_r > MAX_COLS) ? ECW'(MAX_COLS) : ECW'(cols_used_r);

  assign new_rows  = (cfg_index == CFG_ROWS_USED) ? cfg_wdata[ROWS_REG_W-1:0] : rows_used_r;
  assign new_cols  = (cfg_index == CFG_COLS_USED) ? cfg_wdata[COLS_REG_W-1:0] : cols_used_r;
  assign new_nr    = (new_rows > MAX_ROWS) ? ERW'(MAX_ROWS) : ERW'(new_rows);
  assign new_nc    = (new_cols > MAX_COLS) ? ECW'(MAX_COLS) : ECW'(new_cols);
  assign free_load = FW'(FW'(new_nr) * FW'(new_nc));

  assign idx        = AW'(row_r * MAX_COLS + col_r);
  assign in_acc     = in_valid && !in_stall;
  assign len_ok     = (in_data.run_length != '0) && (in_data.run_length <= MAX_RUN);
  assign grid_empty = (nr == '0) || (nc == '0);
  assign last_col   = (col_r == CW'(nc - 1'b1));
  assign cnt_nxt    = busy_r[idx] ? '0 : LW'(cnt_r + 1'b1);
  assign run_found  = (cnt_nxt == len_r);
  // registered tag is compared in the cycle after its address went out
  assign rel_hit    = rd_v_r && busy_r[rd_idx_r] && (rd_data_r == tag_r);
  assign out_free   = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (grid_empty || (in_data.operation == OP_ALLOC && !len_ok)) begin
            state_nxt = S_DONE;
          end else if (in_data.operation == OP_ALLOC) begin
            state_nxt = S_ALLOC;
          end else begin
            state_nxt = S_REL;
          end
        end
      end
      S_ALLOC: begin
        if (run_found) begin
          state_nxt = S_FILL;
        end else if (last_col && row_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_FILL: begin
        if (cnt_r == LW'(1)) begin
          state_nxt = S_DONE;
        end
      end
      S_REL: begin
        if (last_col && row_r == RW'(nr - 1'b1)) begin
          state_nxt = S_REL_TAIL;
        end
      end
      S_REL_TAIL: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_used_r <= ROWS_REG_W'(ROWS_RESET);
      cols_used_r <= COLS_REG_W'(COLS_RESET);
      busy_r      <= '0;
      free_r      <= FW'(RST_NR * RST_NC);
      ok_r        <= 1'b0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= (state_r == S_REL);

      if (cfg_we) begin
        rows_used_r <= new_rows;
        cols_used_r <= new_cols;
        busy_r      <= '0;
        free_r      <= free_load;
      end else if (state_r == S_FILL) begin
        busy_r[idx] <= 1'b1;
        free_r      <= free_r - 1'b1;
      end else if (rel_hit) begin
        busy_r[rd_idx_r] <= 1'b0;
        free_r           <= free_r + 1'b1;
      end

      if (state_r == S_IDLE && in_acc) begin
        ok_r <= 1'b0;
      end else if ((state_r == S_FILL && cnt_r == LW'(1)) || rel_hit) begin
        ok_r <= 1'b1;
      end

      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // scan position, item payload and output result
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          tag_r   <= in_data.tag;
          op_r    <= in_data.operation;
          len_r   <= LW'(in_data.run_length);
          cnt_r   <= '0;
          col_r   <= '0;
          start_r <= '0;
          row_r   <= (in_data.operation == OP_ALLOC) ? RW'(nr - 1'b1) : '0;
        end
      end
      S_ALLOC: begin
        if (run_found) begin
          start_r <= CW'(col_r - CW'(len_r) + 1'b1);
          col_r   <= CW'(col_r - CW'(len_r) + 1'b1);
          cnt_r   <= len_r;
        end else if (last_col) begin
          row_r <= row_r - 1'b1;
          col_r <= '0;
          cnt_r <= '0;
        end else begin
          col_r <= col_r + 1'b1;
          cnt_r <= cnt_nxt;
        end
      end
      S_FILL: begin
        col_r <= col_r + 1'b1;
        cnt_r <= cnt_r - 1'b1;
      end
      S_REL: begin
        rd_idx_r <= idx;
        if (last_col) begin
          row_r <= row_r + 1'b1;
          col_r <= '0;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      S_REL_TAIL: ;
      S_DONE: begin
        if (out_free) begin
          out_data_r.success      <= ok_r;
          out_data_r.row          <= (ok_r && op_r == OP_ALLOC)
                                     ? ROW_OUT_W'(row_r) : '0;
          out_data_r.start_column <= COL_OUT_W'(start_r);
          out_data_r.free_cells   <= FREE_OUT_W'(free_r);
        end
      end
      default: ;
    endcase
  end

  // tag store: one write (fill) and one read (used by the release scan) a cycle
  always_ff @(posedge clk) begin
    if (state_r == S_FILL) begin
      tag_mem[idx] <= tag_r;
    end
    rd_data_r <= tag_mem[idx];
  end

  // an accepted item always starts the sequencer
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("item accepted but sequencer stayed idle");

  // a run is only ever written over free cells
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> !busy_r[idx])
    else $error("fill over a busy cell");

  // free count never exceeds the grid
  assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= FW'(CELLS))
    else $error("free count above grid size");

  // release results never carry a position
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REL) |=> (start_r == '0))
    else $error("start column set during release");

endmodule
